FILE: hw/rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and calendar tables shared by the day difference block.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned STAT_W  = 2;

    // Quotient by 100 through a reciprocal: floor(y * 5243 / 2^19) is exact
    // for every 14-bit year.
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned MUL_W        = 27;
    localparam int unsigned QUOT_W       = 8;

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned P365_W        = 23;
    localparam int unsigned SUM_W         = 24;
    localparam int unsigned MSTART_W      = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN     = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ORDER = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
    } gdd_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic [STAT_W-1:0]  status;
    } gdd_out_t;

    // One date after the multiply stage.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [P365_W-1:0]  prev_days;  // (year - 1) * 365
        logic [QUOT_W-1:0]  q_year;     // year / 100
        logic [QUOT_W-1:0]  q_prev;     // (year - 1) / 100
    } gdd_split_t;

    // One date as a running day number.
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] num;
    } gdd_num_t;

    // Days in a month of a common year; zero for a month that does not exist.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of a common year before the first of the month.
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] ms;
        case (m)
            4'd1:    ms = 9'd0;
            4'd2:    ms = 9'd31;
            4'd3:    ms = 9'd59;
            4'd4:    ms = 9'd90;
            4'd5:    ms = 9'd120;
            4'd6:    ms = 9'd151;
            4'd7:    ms = 9'd181;
            4'd8:    ms = 9'd212;
            4'd9:    ms = 9'd243;
            4'd10:   ms = 9'd273;
            4'd11:   ms = 9'd304;
            4'd12:   ms = 9'd334;
            default: ms = 9'd0;
        endcase
        return ms;
    endfunction

endpackage

FILE: hw/rtl/gregorian_day_difference.sv
// ----------------------------------------------------------------------------
// gregorian_day_difference
// Days from a start date to an end date of the Gregorian calendar.
// ----------------------------------------------------------------------------
// Channel   Ports                      Direction  Contents
// input     s_valid s_ready s_data     in         two dates (gdd_in_t)
// result    m_valid m_ready m_data     out        day count, status (gdd_out_t)
//
// One transfer in and one out per cycle while the result side does not stall; an
// item taken into the input register at its input transfer passes through the
// multiply, day number and result registers before it is offered as a result.
// The pipeline has four stages, each of which holds one item. A stall on the
// result side fills the stages from the output back before s_ready drops.
// Reset is synchronous and empties every stage.
// ----------------------------------------------------------------------------
module gregorian_day_difference
    import gdd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gdd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gdd_out_t m_data
);

    logic       in_valid_reg;
    logic       split_valid_reg;
    logic       num_valid_reg;
    logic       out_valid_reg;

    gdd_in_t    in_reg;
    gdd_split_t start_split_reg;
    gdd_split_t end_split_reg;
    gdd_num_t   start_num_reg;
    gdd_num_t   end_num_reg;
    gdd_out_t   out_reg;

    gdd_split_t start_split_next;
    gdd_split_t end_split_next;
    gdd_num_t   start_num_next;
    gdd_num_t   end_num_next;
    gdd_out_t   out_next;

    logic       out_ready;
    logic       num_ready;
    logic       split_ready;

    // A stage takes a new item when it is empty or its item moves on.
    assign out_ready   = !out_valid_reg || m_ready;
    assign num_ready   = !num_valid_reg || out_ready;
    assign split_ready = !split_valid_reg || num_ready;
    assign s_ready     = !in_valid_reg || split_ready;

    gdd_year_split u_start_split (
        .day   (in_reg.start_day),
        .month (in_reg.start_month),
        .year  (in_reg.start_year),
        .split (start_split_next)
    );

    gdd_year_split u_end_split (
        .day   (in_reg.end_day),
        .month (in_reg.end_month),
        .year  (in_reg.end_year),
        .split (end_split_next)
    );

    gdd_day_num u_start_num (
        .split    (start_split_reg),
        .date_num (start_num_next)
    );

    gdd_day_num u_end_num (
        .split    (end_split_reg),
        .date_num (end_num_next)
    );

    // The range check takes precedence over the order check.
    always_comb begin
        out_next.day_count = '0;
        out_next.status    = STATUS_OK;
        if (!start_num_reg.ok || !end_num_reg.ok) begin
            out_next.status = STATUS_RANGE;
        end else if (end_num_reg.num < start_num_reg.num) begin
            out_next.status = STATUS_ORDER;
        end else begin
            out_next.day_count = end_num_reg.num - start_num_reg.num;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            split_valid_reg <= 1'b0;
            num_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (split_ready) begin
                split_valid_reg <= in_valid_reg;
            end
            if (num_ready) begin
                num_valid_reg <= split_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= num_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_reg <= s_data;
        end
        if (split_ready) begin
            start_split_reg <= start_split_next;
            end_split_reg   <= end_split_next;
        end
        if (num_ready) begin
            start_num_reg <= start_num_next;
            end_num_reg   <= end_num_next;
        end
        if (out_ready) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: hw/rtl/gdd_year_split.sv
// ----------------------------------------------------------------------------
// gdd_year_split
// Multiply stage for one date: days of the whole years before it and the
// century quotients of the year and of the year before.
// ----------------------------------------------------------------------------
module gdd_year_split
    import gdd_pkg::*;
(
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output gdd_split_t         split
);

    logic [YEAR_W-1:0] prev;
    logic [MUL_W-1:0]  prod_year;
    logic [MUL_W-1:0]  prod_prev;

    assign prev      = year - YEAR_MIN;
    assign prod_year = MUL_W'(year) * MUL_W'(DIV100_MUL);
    assign prod_prev = MUL_W'(prev) * MUL_W'(DIV100_MUL);

    always_comb begin
        split.day       = day;
        split.month     = month;
        split.year      = year;
        split.prev_days = P365_W'(prev) * P365_W'(DAYS_PER_YEAR);
        split.q_year    = prod_year[DIV100_SHIFT +: QUOT_W];
        split.q_prev    = prod_prev[DIV100_SHIFT +: QUOT_W];
    end

endmodule

FILE: hw/rtl/gdd_day_num.sv
// ----------------------------------------------------------------------------
// gdd_day_num
// Leap year test, range check and running day number of one date.
// ----------------------------------------------------------------------------
module gdd_day_num
    import gdd_pkg::*;
(
    input  gdd_split_t split,
    output gdd_num_t   date_num
);

    logic [YEAR_W-1:0] prev;
    logic              century;
    logic              leap;
    logic [DAY_W-1:0]  len;
    logic [SUM_W-1:0]  sum;

    assign prev = split.year - YEAR_MIN;

    // A year is a multiple of 100 exactly when its century quotient differs
    // from that of the year before; it is a multiple of 400 when that
    // quotient is also a multiple of four.
    assign century = (split.q_year != split.q_prev);
    assign leap    = (split.year[1:0] == 2'b00) && (!century || split.q_year[1:0] == 2'b00);

    always_comb begin
        len = month_len(split.month);
        if (split.month == MONTH_FEB && leap) begin
            len = FEB_LEAP_LEN;
        end
    end

    always_comb begin
        sum = SUM_W'(split.prev_days)
            + SUM_W'(prev >> 2)
            - SUM_W'(split.q_prev)
            + SUM_W'(split.q_prev >> 2)
            + SUM_W'(month_start(split.month))
            + SUM_W'(split.day)
            + SUM_W'(leap && (split.month > MONTH_FEB));
    end

    always_comb begin
        date_num.ok = (split.year inside {[YEAR_MIN:YEAR_MAX]})
                   && (split.month inside {[MONTH_JAN:MONTH_DEC]})
                   && (split.day != '0)
                   && (split.day <= len);
        date_num.num = sum[COUNT_W-1:0];
    end

endmodule

FILE: hw/rtl/gdd_checker.sv
// ----------------------------------------------------------------------------
// gdd_checker
// Port-level checks of the day difference block, bound to its top level.
// ----------------------------------------------------------------------------
module gdd_checker
    import gdd_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input gdd_out_t m_data
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd3652058;

    // The pipeline is empty after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A result that is taken frees every stage, so the input side is open.
    assert property (@(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready)
        else $error("input stalled while the result side accepts");

    // Any error status carries a zero count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STATUS_OK |-> m_data.day_count == '0)
        else $error("nonzero day count with error status");

    // No span in the calendar exceeds the distance between its ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.day_count <= COUNT_MAX)
        else $error("day count beyond the calendar span");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind gregorian_day_difference gdd_checker u_gdd_checker (.*);

FILE: verif/gregorian_day_difference_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_day_difference_tb
// Self-checking bench for the Gregorian day difference block. A table of
// directed date pairs runs first. Random pairs follow in four phases that
// differ in sender idling and receiver stalling. Every result is compared
// with a pinned expectation or with a calendar model kept in the bench.
// ----------------------------------------------------------------------------
module gregorian_day_difference_tb;
    import gdd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned ITEMS_PER_PHASE = 310;
    localparam int unsigned N_PHASES        = 4;
    localparam int unsigned LAST_YEAR       = 9999;

    typedef struct {
        int unsigned d;
        int unsigned m;
        int unsigned y;
    } civil_date_t;

    typedef struct {
        gdd_in_t  dates;
        bit       pinned;
        gdd_out_t want;
    } probe_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    gdd_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    gdd_out_t m_data;

    // Expectation attached to the pair currently offered on the input side.
    bit       offered_pinned;
    gdd_out_t offered_want;

    gdd_out_t    pending_gaps[$];
    probe_t      probes[$];
    int unsigned mismatches = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_in_order = 0;
    int unsigned n_reversed = 0;
    int unsigned n_invalid  = 0;
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;

    gregorian_day_difference u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------
    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        case (m)
            2:             return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic bit date_ok(civil_date_t c);
        if (c.y < 1 || c.y > LAST_YEAR) return 1'b0;
        if (c.m < 1 || c.m > 12) return 1'b0;
        return (c.d >= 1) && (c.d <= month_length(c.m, c.y));
    endfunction

    // Running day count with 1 January of year 1 as day 1.
    function automatic int unsigned serial_day(civil_date_t c);
        int unsigned p;
        int unsigned n;
        p = c.y - 1;
        n = p * 365 + p / 4 - p / 100 + p / 400 + c.d;
        for (int unsigned k = 1; k < c.m; k++) n += month_length(k, c.y);
        return n;
    endfunction

    function automatic gdd_out_t predict_gap(gdd_in_t x);
        civil_date_t a;
        civil_date_t b;
        gdd_out_t    r;
        a.d = x.start_day;
        a.m = x.start_month;
        a.y = x.start_year;
        b.d = x.end_day;
        b.m = x.end_month;
        b.y = x.end_year;
        r.day_count = '0;
        r.status    = STATUS_OK;
        if (!date_ok(a) || !date_ok(b)) begin
            r.status = STATUS_RANGE;
        end else if (serial_day(b) < serial_day(a)) begin
            r.status = STATUS_ORDER;
        end else begin
            r.day_count = COUNT_W'(serial_day(b) - serial_day(a));
        end
        return r;
    endfunction

    function automatic gdd_in_t pack_dates(civil_date_t a, civil_date_t b);
        gdd_in_t x;
        x.start_day   = DAY_W'(a.d);
        x.start_month = MONTH_W'(a.m);
        x.start_year  = YEAR_W'(a.y);
        x.end_day     = DAY_W'(b.d);
        x.end_month   = MONTH_W'(b.m);
        x.end_year    = YEAR_W'(b.y);
        return x;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_probe(int unsigned sd, int unsigned sm, int unsigned sy,
                             int unsigned ed, int unsigned em, int unsigned ey,
                             bit pinned, int unsigned count, logic [STAT_W-1:0] stat);
        civil_date_t a;
        civil_date_t b;
        probe_t      p;
        a.d = sd;
        a.m = sm;
        a.y = sy;
        b.d = ed;
        b.m = em;
        b.y = ey;
        p.dates          = pack_dates(a, b);
        p.pinned         = pinned;
        p.want.day_count = COUNT_W'(count);
        p.want.status    = stat;
        probes.insert(probes.size(), p);
    endtask

    // Valid date, leaning toward century years and the last day of a month.
    function automatic civil_date_t random_date();
        civil_date_t c;
        int unsigned len;
        if ($urandom_range(3) == 0) begin
            c.y = $urandom_range(1, 99) * 100 + $urandom_range(2) - 1;
        end else begin
            c.y = $urandom_range(1, LAST_YEAR);
        end
        c.m = $urandom_range(1, 12);
        len = month_length(c.m, c.y);
        c.d = ($urandom_range(9) < 3) ? len : $urandom_range(1, len);
        return c;
    endfunction

    function automatic gdd_in_t random_pair();
        civil_date_t a;
        civil_date_t b;
        civil_date_t tmp;
        int unsigned kind;
        int unsigned len;
        logic [63:0] noise;
        kind = $urandom_range(99);
        a = random_date();
        b = random_date();
        if (kind < 30) begin
            // Keep both dates close so that short spans are common.
            b.y = a.y + $urandom_range(2);
            if (b.y > LAST_YEAR) b.y = LAST_YEAR;
            len = month_length(b.m, b.y);
            if (b.d > len) b.d = len;
        end
        if (kind < 5) b = a;
        if (kind < 75) begin
            if (serial_day(b) < serial_day(a)) begin
                tmp = a;
                a = b;
                b = tmp;
            end
        end else if (kind < 88) begin
            if (serial_day(b) > serial_day(a)) begin
                tmp = a;
                a = b;
                b = tmp;
            end
        end else if (kind < 94) begin
            noise = {$urandom, $urandom};
            return noise[$bits(gdd_in_t)-1:0];
        end else begin
            // Push one field of one date out of the calendar.
            len = month_length(a.m, a.y);
            case ($urandom_range(2))
                0: a.d = (len < 31 && $urandom_range(1) == 1) ?
                         $urandom_range(len + 1, 31) : 0;
                1: a.m = ($urandom_range(1) == 1) ? $urandom_range(13, 15) : 0;
                default: a.y = ($urandom_range(1) == 1) ?
                               $urandom_range(LAST_YEAR + 1, 16383) : 0;
            endcase
            if ($urandom_range(1) == 1) begin
                tmp = a;
                a = b;
                b = tmp;
            end
        end
        return pack_dates(a, b);
    endfunction

    task automatic send_pair(gdd_in_t dates, bit pinned, gdd_out_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data         <= dates;
        offered_pinned <= pinned;
        offered_want   <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_gaps.size() == 0);
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        gdd_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_gaps.insert(pending_gaps.size(),
                                    offered_pinned ? offered_want : predict_gap(s_data));
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (pending_gaps.size() == 0) begin
                    report_mismatch("result with nothing pending", m_data.day_count, 0);
                end else begin
                    want = pending_gaps.pop_front();
                    n_checked++;
                    if (want.status == STATUS_OK) n_in_order++;
                    else if (want.status == STATUS_ORDER) n_reversed++;
                    else n_invalid++;
                    if (m_data.day_count !== want.day_count)
                        report_mismatch("day_count", m_data.day_count, want.day_count);
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // The run ends here if no transfer happens for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        s_valid        <= 1'b0;
        s_data         <= '0;
        offered_pinned <= 1'b0;
        offered_want   <= '0;
        aresetn        <= 1'b0;

        // Minimum and maximum dates, the full span and its reverse.
        add_probe( 1,  1,     1,  1,  1,     1, 1, 0,       STATUS_OK);
        add_probe( 1,  1,     1, 31, 12,  9999, 1, 3652058, STATUS_OK);
        add_probe(31, 12,  9999,  1,  1,     1, 1, 0,       STATUS_ORDER);
        add_probe(31, 12,  9999, 31, 12,  9999, 1, 0,       STATUS_OK);
        // Leap rule around centuries and ordinary years.
        add_probe(28,  2,  1900,  1,  3,  1900, 0, 0,       STATUS_OK);
        add_probe(29,  2,  1900,  1,  3,  1900, 1, 0,       STATUS_RANGE);
        add_probe(29,  2,  2000,  1,  3,  2000, 0, 0,       STATUS_OK);
        add_probe(29,  2,  2004, 29,  2,  2008, 0, 0,       STATUS_OK);
        add_probe(29,  2,  2001,  1,  3,  2001, 1, 0,       STATUS_RANGE);
        // Months, days and years outside the calendar.
        add_probe( 1,  0,  2000,  1,  1,  2000, 1, 0,       STATUS_RANGE);
        add_probe( 1,  1,  2000,  1, 13,  2000, 1, 0,       STATUS_RANGE);
        add_probe( 1, 15,  2000,  1,  1,  2001, 1, 0,       STATUS_RANGE);
        add_probe( 0,  1,  2000,  1,  1,  2000, 1, 0,       STATUS_RANGE);
        add_probe(31,  4,  2000,  1,  5,  2000, 1, 0,       STATUS_RANGE);
        add_probe( 1,  1,     0,  1,  1,     1, 1, 0,       STATUS_RANGE);
        add_probe( 1,  1,     1,  1,  1, 10000, 1, 0,       STATUS_RANGE);
        add_probe( 1,  1, 16383,  1,  1,  9999, 1, 0,       STATUS_RANGE);
        // A bad date wins over a reversed order; a plain reversal and ordinary spans follow.
        add_probe( 1,  1,  2000,  0,  1,  1999, 1, 0,       STATUS_RANGE);
        add_probe( 2,  1,  2000,  1,  1,  2000, 1, 0,       STATUS_ORDER);
        add_probe(31,  1,  2000, 31, 12,  2000, 0, 0,       STATUS_OK);
        add_probe(31, 12,  1999,  1,  1,  2000, 0, 0,       STATUS_OK);
        add_probe(15,  6,  1600, 15,  6,  2400, 0, 0,       STATUS_OK);
        add_probe(31,  1,  2023, 28,  2,  2023, 0, 0,       STATUS_OK);
        add_probe(30, 11,  8191,  1, 12,  8191, 0, 0,       STATUS_OK);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) send_pair(probes[i].dates, probes[i].pinned, probes[i].want);

        for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
            // The sender holds off until the pipeline has drained.
            settle_idle();
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) send_pair(random_pair(), 1'b0, '0);
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results for %0d date pairs under four idle and stall patterns.",
                 n_checked, n_accepted);
        $display("Outcomes: %0d in order, %0d reversed, %0d outside the calendar.",
                 n_in_order, n_reversed, n_invalid);
        if (mismatches == 0 && pending_gaps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
